[hdl/gcd_pkg.sv]
// ============================================================================
// gcd_pkg
// Shared types and constants for the Euclidean GCD core: the command and
// status groups exchanged between the controller and the datapath.
// ============================================================================
`default_nettype none

package gcd_pkg;

    // Width of the operand and result fields on the ports.
    localparam int FIELD_WIDTH = 32;

    // Commands issued by the controller to the datapath.
    typedef struct packed {
        logic load;      // capture new operands, ordered as big/small
        logic div_init;  // start a remainder computation of big by small
        logic div_step;  // one shift-subtract step of the remainder
        logic out_load;  // move the finished GCD into the result register
    } ctrl_cmd_t;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic zero_hit;  // big or small is zero, so the GCD is known
        logic div_last;  // the current step is the last one of the remainder
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/gcd_dp.sv]
// ============================================================================
// gcd_dp
// Datapath of the Euclidean GCD core: operand registers, a restoring
// shift-subtract remainder unit and the result register.
// ============================================================================
`default_nettype none

module gcd_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic [gcd_pkg::FIELD_WIDTH-1:0] first_value,
    input  wire logic [gcd_pkg::FIELD_WIDTH-1:0] second_value,
    input  wire gcd_pkg::ctrl_cmd_t             cmd,
    output gcd_pkg::dp_status_t                 status,
    output logic [gcd_pkg::FIELD_WIDTH-1:0]     divisor_result
);

    localparam int W    = OPERAND_WIDTH;
    localparam int FW   = gcd_pkg::FIELD_WIDTH;
    localparam int CNTW = $clog2(W);

    logic [W-1:0]    big_reg,    big_next;
    logic [W-1:0]    small_reg,  small_next;
    logic [W-1:0]    rem_reg,    rem_next;
    logic [W-1:0]    shift_reg,  shift_next;
    logic [CNTW-1:0] count_reg,  count_next;
    logic [FW-1:0]   result_reg, result_next;

    logic [W-1:0]    op_a;
    logic [W-1:0]    op_b;
    logic [W:0]      trial;
    logic [W:0]      trial_diff;
    logic [W-1:0]    rem_step;

    // Operands are reduced or zero-extended to the datapath width.
    assign op_a = W'(first_value);
    assign op_b = W'(second_value);

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor when it fits.
    assign trial      = {rem_reg, shift_reg[W-1]};
    assign trial_diff = trial - {1'b0, small_reg};
    assign rem_step   = trial_diff[W] ? trial[W-1:0] : trial_diff[W-1:0];

    // Status toward the controller.
    assign status.zero_hit = (big_reg == '0) || (small_reg == '0);
    assign status.div_last = (count_reg == '0);

    // Next-state logic of the datapath registers.
    always_comb
    begin
        big_next    = big_reg;
        small_next  = small_reg;
        rem_next    = rem_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            if (op_a > op_b)
            begin
                big_next   = op_a;
                small_next = op_b;
            end
            else
            begin
                big_next   = op_b;
                small_next = op_a;
            end
        end

        if (cmd.div_init)
        begin
            rem_next   = '0;
            shift_next = big_reg;
            count_next = CNTW'(W - 1);
        end

        if (cmd.div_step)
        begin
            rem_next   = rem_step;
            shift_next = {shift_reg[W-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            // The Euclid step completes with the last remainder bit.
            if (status.div_last)
            begin
                big_next   = small_reg;
                small_next = rem_step;
            end
        end

        // At least one of the two is zero here, so OR gives the other value.
        if (cmd.out_load)
        begin
            result_next = FW'(big_reg | small_reg);
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        big_reg    <= big_next;
        small_reg  <= small_next;
        rem_reg    <= rem_next;
        shift_reg  <= shift_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign divisor_result = result_reg;

endmodule

`default_nettype wire

[hdl/gcd_ctrl.sv]
// ============================================================================
// gcd_ctrl
// Controller of the Euclidean GCD core: sequences operand load, remainder
// steps and result hand-off, and owns the handshake of both channels.
// ============================================================================
`default_nettype none

module gcd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire gcd_pkg::dp_status_t status,
    output gcd_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Command decode and next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // A waiting result leaves once the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.zero_hit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                // Wait until the result register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[hdl/gcd_euclidean_core.sv]
// ============================================================================
// gcd_euclidean_core
// Greatest common divisor of two unsigned operands by Euclid's remainder
// method, with a bit-serial restoring remainder unit.
// ============================================================================
//
//  Channel  | Signals                               | Direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_ready, first_value,       | in
//           | second_value                           |
//  output   | out_valid, out_ready, divisor_result   | out
//
// A transaction runs k Euclid remainder steps, at most about 46 for 32-bit
// operands. Each remainder step runs OPERAND_WIDTH shift-subtract iterations
// through the single remainder unit plus one check.
// Reset is asynchronous and active low; no clearing pass is needed.
// The result register lets a new transaction start while the previous result
// still waits; a stalled output only holds the core in its finish state.
// ============================================================================
`default_nettype none

module gcd_euclidean_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [gcd_pkg::FIELD_WIDTH-1:0] first_value,
    input  wire logic [gcd_pkg::FIELD_WIDTH-1:0] second_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [gcd_pkg::FIELD_WIDTH-1:0]      divisor_result
);

    gcd_pkg::ctrl_cmd_t  cmd;
    gcd_pkg::dp_status_t status;

    // Controller.
    gcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    gcd_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk            (clk),
        .first_value    (first_value),
        .second_value   (second_value),
        .cmd            (cmd),
        .status         (status),
        .divisor_result (divisor_result)
    );

    // An accepted transaction keeps the core busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("core accepted back-to-back transactions");

    // Remainder steps never run while the core advertises it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ready)
    else $error("division step while idle");

    // A result is released only once one operand has reached zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.zero_hit)
    else $error("result released before Euclid finished");

    // A new result appears only after the result register was loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
    else $error("out_valid rose without a result load");

endmodule

`default_nettype wire

[verif/gcd_euclidean_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// gcd_euclidean_checker
// Watches both channels of the GCD core, predicts each result from the
// accepted operand pair and compares it with the result that comes back.
// ============================================================================

module gcd_euclidean_checker #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0] first_value,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0] second_value,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0] divisor_result,
    output int unsigned                     fail_count,
    output int unsigned                     pending_count,
    output int unsigned                     result_count
);

    localparam int FW = gcd_pkg::FIELD_WIDTH;

    typedef struct {
        logic [FW-1:0] first;
        logic [FW-1:0] second;
        logic [FW-1:0] gcd;
    } gcd_job_t;

    gcd_job_t expected_gcd_q[$];

    // Euclid's remainder method on operands cut to the datapath width.
    function automatic logic [FW-1:0] euclid_gcd(input logic [FW-1:0] a,
                                                 input logic [FW-1:0] b);
        logic [63:0] mask;
        logic [63:0] greater;
        logic [63:0] lesser;
        logic [63:0] rem;
        mask    = (OPERAND_WIDTH >= 64) ? '1 : ((64'd1 << OPERAND_WIDTH) - 64'd1);
        greater = (64'(a) & mask) > (64'(b) & mask) ? (64'(a) & mask) : (64'(b) & mask);
        lesser  = (64'(a) & mask) > (64'(b) & mask) ? (64'(b) & mask) : (64'(a) & mask);
        while (greater != 64'd0 && lesser != 64'd0)
        begin
            rem     = greater % lesser;
            greater = lesser;
            lesser  = rem;
        end
        return FW'((greater > lesser ? greater : lesser) & mask);
    endfunction

    // Record each accepted operand pair and check each accepted result.
    always @(posedge clk)
    begin
        gcd_job_t job;
        if (!rst_n)
        begin
            expected_gcd_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
            result_count  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                job.first  = first_value;
                job.second = second_value;
                job.gcd    = euclid_gcd(first_value, second_value);
                expected_gcd_q.insert(expected_gcd_q.size(), job);
            end
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_gcd_q.size() == 0)
                begin
                    $display("ERROR t=%0t: expected no result, actual %h",
                             $time, divisor_result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    job = expected_gcd_q.pop_front();
                    if (divisor_result !== job.gcd)
                    begin
                        $display("ERROR t=%0t: gcd(%h, %h) expected %h actual %h",
                                 $time, job.first, job.second, job.gcd,
                                 divisor_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_gcd_q.size();
        end
    end

endmodule

[verif/tb_gcd_euclidean_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_gcd_euclidean_core
// Regression for the Euclidean GCD core: directed corner operands, then
// mixed random operand pairs under random stalls on both channels.
// ============================================================================

module tb_gcd_euclidean_core;

    localparam int FW            = gcd_pkg::FIELD_WIDTH;
    localparam int OPERAND_WIDTH = 32;
    localparam int RANDOM_PAIRS  = 400;
    localparam int RECEIVER_HOLD = 5000;
    localparam int DRAIN_CYCLES  = 2000;
    localparam int CYCLE_LIMIT   = 4000000;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [FW-1:0] first_value;
    logic [FW-1:0] second_value;
    logic          out_valid;
    logic          out_ready;
    logic [FW-1:0] divisor_result;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned result_count;
    int unsigned cycle_count = 0;
    int          directed_sent = 0;
    int          random_sent = 0;

    gcd_euclidean_core #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_value    (first_value),
        .second_value   (second_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .divisor_result (divisor_result)
    );

    gcd_euclidean_checker #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_value    (first_value),
        .second_value   (second_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .divisor_result (divisor_result),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    // Free-running clock.
    always #2 clk = ~clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 4);
        else if (roll < 98)
            return $urandom_range(5, 40);
        else
            return $urandom_range(100, 400);
    endfunction

    // Offer one operand pair after an optional gap and wait for the transaction.
    task automatic send_pair(input logic [FW-1:0] a, input logic [FW-1:0] b,
                             input int gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_value  <= a;
        second_value <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("gcd_euclidean_core regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, runs of steady acceptance and one long
    // hold-off once traffic is flowing, so the core backs up onto its input.
    initial
    begin : result_sink
        int  run_len;
        int  gap_len;
        bit  held;
        held = 1'b0;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!held && result_count >= 40)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (RECEIVER_HOLD) @(posedge clk);
            end
            out_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(500, 3000)
                                                  : $urandom_range(1, 60);
            repeat (run_len) @(posedge clk);
            gap_len = idle_gap();
            if (gap_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
    end

    // Operand side: reset, directed corners, then random pairs.
    initial
    begin : operand_source
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        logic [FW-1:0] fib_lo;
        logic [FW-1:0] fib_hi;
        logic [FW-1:0] fib_next;
        logic [63:0]   factor;
        int            kind;
        bit            burst;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        first_value  <= '0;
        second_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero operands, equal operands, extremes, worst-case
        // consecutive Fibonacci numbers and a few known answers.
        send_pair(32'h0000_0000, 32'h0000_0000, idle_gap());
        send_pair(32'h0000_0000, 32'h0000_0001, idle_gap());
        send_pair(32'h0000_0001, 32'h0000_0000, idle_gap());
        send_pair(32'h0000_0000, 32'hFFFF_FFFF, idle_gap());
        send_pair(32'hFFFF_FFFF, 32'h0000_0000, idle_gap());
        send_pair(32'h0000_0001, 32'h0000_0001, idle_gap());
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, idle_gap());
        send_pair(32'h1234_5678, 32'h1234_5678, idle_gap());
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, idle_gap());
        send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, idle_gap());
        send_pair(32'h0000_0001, 32'hFFFF_FFFF, idle_gap());
        send_pair(32'hFFFF_FFFF, 32'h0000_0001, idle_gap());
        send_pair(32'h8000_0000, 32'h4000_0000, idle_gap());
        send_pair(32'h8000_0000, 32'hFFFF_FFFF, idle_gap());
        send_pair(32'hB119_24E1, 32'h6D73_E55F, idle_gap());
        send_pair(32'h6D73_E55F, 32'hB119_24E1, idle_gap());
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, idle_gap());
        send_pair(32'hFFFF_0000, 32'h0000_FFFF, idle_gap());
        send_pair(32'd48, 32'd18, idle_gap());
        send_pair(32'd7, 32'd13, idle_gap());
        send_pair(32'hDEAD_BEEF, 32'h0000_0003, idle_gap());
        directed_sent = 21;

        // Let every directed result come back before the random part.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);

        // Random pairs of several shapes, with bursts that never idle.
        burst = 1'b0;
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i % 25 == 0)
                burst = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            case (kind) inside
                // Both operands fully random.
                0, 1, 2:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                // Multiples of a common factor, so the answer is not one.
                3, 4:
                begin
                    factor = $urandom_range(2, 65535);
                    a = FW'(factor * ({32'd0, $urandom} % (64'h1_0000_0000 / factor)));
                    b = FW'(factor * ({32'd0, $urandom} % (64'h1_0000_0000 / factor)));
                end
                // Small operands.
                5:
                begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end
                // One side zero.
                6:
                begin
                    a = $urandom;
                    b = '0;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        b = a;
                        a = '0;
                    end
                end
                // Equal operands.
                7:
                begin
                    a = $urandom;
                    b = a;
                end
                // Consecutive Fibonacci numbers take the most remainder steps.
                8:
                begin
                    fib_lo = 1;
                    fib_hi = 1;
                    repeat ($urandom_range(1, 45))
                    begin
                        fib_next = fib_lo + fib_hi;
                        fib_lo   = fib_hi;
                        fib_hi   = fib_next;
                    end
                    a = fib_hi;
                    b = fib_lo;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        a = fib_lo;
                        b = fib_hi;
                    end
                end
                // Powers of two against shifted random values.
                default:
                begin
                    a = 32'd1 << $urandom_range(0, 31);
                    b = $urandom << $urandom_range(0, 31);
                end
            endcase
            send_pair(a, b, burst ? 0 : idle_gap());
            random_sent++;
        end
        in_valid <= 1'b0;

        // Drain, then give the core time to show any stray result.
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d directed and %0d random operand pairs, %0d results checked,",
                 directed_sent, random_sent, result_count);
        $display("including zero and equal operands, Fibonacci pairs and a %0d-cycle output stall.",
                 RECEIVER_HOLD);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("gcd_euclidean_core regression: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d transactions without a result",
                     fail_count, pending_count);
            $display("gcd_euclidean_core regression: fail");
        end
        $finish;
    end

endmodule
